FILE: hw/rtl/bbp_pkg.sv
// Shared types, constants and the arctangent table for the band-pass biquad.
// No dependencies.
package bbp_pkg;

	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 40;
	localparam int CORD_W    = 34;
	localparam int COEF_W    = 31;
	localparam int RATE_W    = 18;
	localparam int FREQ_W    = 22;
	localparam int QUAL_W    = 20;

	localparam logic [QUAL_W-1:0]        Q_FLOOR         = 20'd41;
	localparam logic signed [CORD_W-1:0] CORDIC_INV_GAIN = 34'sh026DD3B6A;
	localparam logic [RATE_W-1:0]        RATE_RESET      = 18'd48000;
	localparam logic [DIV_NUM_W-1:0]     COEF_LIMIT      = 64'd536870912;

	typedef logic signed [CORD_W-1:0]  cord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [DIV_DEN_W-1:0] alpha_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/tunable_biquad_bandpass.sv
// Retunable band-pass biquad: sequencer, shared divider, CORDIC and one MAC.
// Each input beat runs up to five divides on the one divider and one CORDIC rotation
// before the MAC (the phase divide is skipped with sample_rate 0).
// One beat in flight: a new beat is taken only once the last result is registered.
// Output register lets the next beat enter while a result waits.
// arst_n clears state, delay line and sets sample_rate to 48000.
module tunable_biquad_bandpass
	import bbp_pkg::*;
#(
	parameter int SAMPLE_BITS  = 24,
	parameter int CORDIC_STEPS = 20
)(
	input  logic clk,
	input  logic arst_n,
	input  logic                                            s_tvalid,
	output logic                                            s_tready,
	// sample_in, centre_freq, quality
	input  logic [((SAMPLE_BITS+FREQ_W+QUAL_W+7)/8)*8-1:0] s_tdata,
	output logic                                            m_tvalid,
	input  logic                                            m_tready,
	// sample_out
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]               m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SB   = SAMPLE_BITS;
	localparam int OW   = ((SAMPLE_BITS+7)/8)*8;
	localparam int PW   = COEF_W + SB;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PHASE = 4'd1;
	localparam logic [3:0] ST_CGO   = 4'd2;
	localparam logic [3:0] ST_CORD  = 4'd3;
	localparam logic [3:0] ST_ALPHA = 4'd4;
	localparam logic [3:0] ST_A0    = 4'd5;
	localparam logic [3:0] ST_B0    = 4'd6;
	localparam logic [3:0] ST_A1    = 4'd7;
	localparam logic [3:0] ST_A2    = 4'd8;
	localparam logic [3:0] ST_MAC   = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;

	localparam logic signed [63:0] SMAX = (64'sd1 <<< (SB-1)) - 64'sd1;
	localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

	logic [3:0]            state_q;
	logic [RATE_W-1:0]     rate_q;
	logic signed [SB-1:0]  x0_q, d1_q, d2_q, y1_q, y2_q;
	logic [QUAL_W-1:0]     qual_q;
	logic [31:0]           phase_q;
	cord_t                 cos_q;
	alpha_t                alpha_q;
	coef_t                 b0_q, a1_q, a2_q;
	logic                  neg_q;
	div_req_t              req_q;
	logic [2:0]            mcnt_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [63:0]    acc_q;
	logic                  m_tvalid_q;
	logic [OW-1:0]         m_tdata_q;

	logic                  div_done, cord_done;
	logic [DIV_NUM_W-1:0]  quo;
	cord_t                 sin_w, cos_w;
	alpha_t                a0;
	logic [QUAL_W-1:0]     qual_in;
	logic [DIV_NUM_W-1:0]  coef_mag;
	coef_t                 coef_res;
	logic signed [63:0]    num_b0, num_a1, num_a2, num_s;
	logic signed [COEF_W-1:0] mcoef;
	logic signed [SB-1:0]  mop;
	logic signed [63:0]    rnd, y_full;
	logic signed [SB-1:0]  y_sat;
	logic                  out_free;
	logic                  cfg_wr;

	bbp_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_q),
		.done     (div_done),
		.quotient (quo)
	);

	bbp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_CGO),
		.phase  (phase_q),
		.done   (cord_done),
		.sin_o  (sin_w),
		.cos_o  (cos_w)
	);

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && !paddr[2];
	assign prdata   = paddr[2] ? 32'd0 : {{(32-RATE_W){1'b0}}, rate_q};
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign qual_in  = s_tdata[SB+FREQ_W +: QUAL_W];
	assign a0       = alpha_q + alpha_t'(40'sd1073741824);
	assign num_b0   = 64'(alpha_q) <<< 24;
	assign num_a1   = 64'(cos_q) <<< 25;
	assign num_a2   = (64'(alpha_q) - 64'sd1073741824) <<< 24;
	assign num_s    = 64'(sin_w) <<< 11;
	assign coef_mag = (quo > COEF_LIMIT) ? COEF_LIMIT : quo;
	assign coef_res = neg_q ? -coef_t'(coef_mag[COEF_W-1:0]) : coef_t'(coef_mag[COEF_W-1:0]);

	always_comb begin
		case (mcnt_q[1:0])
			2'd0:    begin mcoef = b0_q;  mop = x0_q; end
			2'd1:    begin mcoef = -b0_q; mop = d2_q; end
			2'd2:    begin mcoef = a1_q;  mop = y1_q; end
			default: begin mcoef = a2_q;  mop = y2_q; end
		endcase
	end

	assign rnd    = acc_q + 64'sd8388608;
	assign y_full = rnd >>> 24;
	assign y_sat  = (y_full > SMAX) ? SB'(SMAX) : ((y_full < SMIN) ? SB'(SMIN) : SB'(y_full));

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [DIV_DEN_W-1:0] magden(input alpha_t v);
		return v[DIV_DEN_W-1] ? DIV_DEN_W'(-v) : DIV_DEN_W'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rate_q     <= RATE_RESET;
			req_q      <= '0;
			m_tvalid_q <= 1'b0;
			mcnt_q     <= '0;
			d1_q       <= '0;
			d2_q       <= '0;
			y1_q       <= '0;
			y2_q       <= '0;
		end else begin
			req_q.start <= 1'b0;
			if (cfg_wr)
				rate_q <= pwdata[RATE_W-1:0];
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (rate_q == '0) begin
							state_q <= ST_CGO;
						end else begin
							req_q.start <= 1'b1;
							req_q.num   <= DIV_NUM_W'({s_tdata[SB +: FREQ_W], 28'd0});
							req_q.den   <= DIV_DEN_W'(rate_q);
							state_q     <= ST_PHASE;
						end
					end
				end
				ST_PHASE: if (div_done) state_q <= ST_CGO;
				ST_CGO:   state_q <= ST_CORD;
				ST_CORD: begin
					if (cord_done) begin
						req_q.start <= 1'b1;
						req_q.num   <= mag64(num_s);
						req_q.den   <= DIV_DEN_W'((qual_q < Q_FLOOR) ? Q_FLOOR : qual_q);
						state_q     <= ST_ALPHA;
					end
				end
				ST_ALPHA: begin
					if (div_done) state_q <= ST_A0;
				end
				ST_A0: begin
					if (a0 == '0) begin
						mcnt_q  <= '0;
						state_q <= ST_MAC;
					end else begin
						req_q.start <= 1'b1;
						req_q.num   <= mag64(num_b0);
						req_q.den   <= magden(a0);
						state_q     <= ST_B0;
					end
				end
				ST_B0: begin
					if (div_done) begin
						req_q.start <= 1'b1;
						req_q.num   <= mag64(num_a1);
						state_q     <= ST_A1;
					end
				end
				ST_A1: begin
					if (div_done) begin
						req_q.start <= 1'b1;
						req_q.num   <= mag64(num_a2);
						state_q     <= ST_A2;
					end
				end
				ST_A2: begin
					if (div_done) begin
						mcnt_q  <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd4) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						d2_q       <= d1_q;
						d1_q       <= x0_q;
						y2_q       <= y1_q;
						y1_q       <= y_sat;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x0_q    <= s_tdata[SB-1:0];
				qual_q  <= qual_in;
				phase_q <= '0;
			end
			ST_PHASE: if (div_done) phase_q <= quo[31:0];
			ST_CORD: begin
				if (cord_done) begin
					cos_q <= cos_w;
					neg_q <= sin_w[CORD_W-1];
				end
			end
			ST_ALPHA: begin
				if (div_done)
					alpha_q <= neg_q ? -alpha_t'(quo[DIV_DEN_W-1:0]) : alpha_t'(quo[DIV_DEN_W-1:0]);
			end
			ST_A0: begin
				b0_q  <= '0;
				a1_q  <= '0;
				a2_q  <= '0;
				acc_q <= '0;
				neg_q <= alpha_q[DIV_DEN_W-1] ^ a0[DIV_DEN_W-1];
			end
			ST_B0: begin
				if (div_done) begin
					b0_q  <= coef_res;
					neg_q <= cos_q[CORD_W-1] ^ a0[DIV_DEN_W-1];
				end
			end
			ST_A1: begin
				if (div_done) begin
					a1_q  <= coef_res;
					neg_q <= num_a2[63] ^ a0[DIV_DEN_W-1];
				end
			end
			ST_A2: begin
				if (div_done) a2_q <= coef_res;
				acc_q <= '0;
			end
			ST_MAC: begin
				if (mcnt_q != 3'd4)
					prod_q <= PW'(mcoef) * PW'(mop);
				if (mcnt_q != 3'd0)
					acc_q <= acc_q + 64'(prod_q);
			end
			ST_DONE: if (out_free) m_tdata_q <= OW'(unsigned'(y_sat));
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_tready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_PHASE || state_q == ST_CGO))
		else $error("accepted beat did not start the phase step");
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done step");
	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (b0_q <= 31'sd536870912 && b0_q >= -31'sd536870912
		&& a1_q <= 31'sd536870912 && a1_q >= -31'sd536870912))
		else $error("coefficient outside saturation range");
`endif

endmodule

FILE: hw/rtl/bbp_divider.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on bbp_pkg.
module bbp_divider
	import bbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_req_t             req,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	assign trial    = {rem_q, quo_q[DIV_NUM_W-1]};
	assign fits     = trial >= {1'b0, den_q};
	assign done     = busy_q && (cnt_q == CNT_W'(DIV_NUM_W));
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q && !done) begin
			rem_q <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

endmodule

FILE: hw/rtl/bbp_cordic.sv
// Iterative rotation-mode CORDIC giving sin and cos of a turn-fraction phase.
// Depends on bbp_pkg.
module bbp_cordic
	import bbp_pkg::*;
#(
	parameter int STEPS = 20
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] phase,
	output logic        done,
	output cord_t       sin_o,
	output cord_t       cos_o
);

	localparam int RUN = (STEPS > 32) ? 32 : STEPS;

	cord_t       x_q, y_q, z_q;
	logic [5:0]  cnt_q;
	logic        busy_q, flip_q;
	cord_t       z_in, z_pre, x_sh, y_sh, ang;
	logic        flip_pre;
	logic [4:0]  idx;

	assign idx  = cnt_q[4:0];
	assign x_sh = x_q >>> idx;
	assign y_sh = y_q >>> idx;
	assign ang  = cord_t'({2'b00, atan_turn(idx)});
	assign done = busy_q && (cnt_q == 6'(RUN));
	assign sin_o = flip_q ? -y_q : y_q;
	assign cos_o = flip_q ? -x_q : x_q;

	always_comb begin
		z_in     = cord_t'({{2{phase[31]}}, phase});
		z_pre    = z_in;
		flip_pre = 1'b0;
		if (z_in >= 34'sh040000000) begin
			z_pre    = z_in - 34'sh080000000;
			flip_pre = 1'b1;
		end else if (z_in < -34'sh040000000) begin
			z_pre    = z_in + 34'sh080000000;
			flip_pre = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_INV_GAIN;
			y_q    <= '0;
			z_q    <= z_pre;
			flip_q <= flip_pre;
		end else if (busy_q && !done) begin
			if (!z_q[CORD_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + ang;
			end
		end
	end

endmodule
